// ===== rtl/core/bbf_pkg.sv =====
// Package with shared constants and types of the box blur filter.
package bbf_pkg;

    localparam int MAX_HEIGHT = 1024;
    localparam int LANES      = 4;
    localparam int CH_W       = 8;
    localparam int CFG_W      = 11;
    localparam int RAD_W      = 2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef logic [CH_W-1:0] t_lane_vec [LANES];

endpackage

// ===== rtl/core/bbf_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module bbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/box_blur_filter_top.sv =====
// Top level of the box blur filter: line store, window accumulation and division.
// Path: a beat that makes an output ready is accepted in IDLE, then CHECK, READ and DIV follow;
// in READ the side*side window, side being 2*radius+1, is read from the line store pixel by pixel.
// o_ready is high only in IDLE, so no new beat is taken while an earlier one is still processed;
// the divide step waits while an earlier result beat is still held by the receiver.
// Reset: synchronous, active low; counters clear and registers return to 640, 480 and 2.
module box_blur_filter_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [31:0] i_pixel_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_pixel_out,
    output logic        o_frame_end,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = CW + 1;
    localparam int HW    = $clog2(bbf_pkg::MAX_HEIGHT) + 1;
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int SIDE  = 2 * MAX_RADIUS + 1;
    localparam int SW    = $clog2(SIDE + 1);
    localparam int AW    = $clog2(SIDE * SIDE + 1);
    localparam int SUMW  = $clog2(255 * SIDE * SIDE + 1);
    localparam int SH    = SUMW + AW;
    localparam int MW    = SH + 1;
    localparam int PW    = SUMW + MW;
    localparam int RB    = $clog2(4 * MAX_RADIUS + 4);
    localparam int DEPTH = (2 ** RB) * (2 ** CW);
    localparam int YW    = HW + 2;
    localparam int XW    = WW + 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_DIV   = 2'd3;

    logic [bbf_pkg::CFG_W-1:0] r_frame_width;
    logic [bbf_pkg::CFG_W-1:0] r_frame_height;
    logic [bbf_pkg::RAD_W-1:0] r_radius;

    logic [1:0]      r_state;
    logic [CW-1:0]   r_in_col;
    logic [HW-1:0]   r_in_row;
    logic [CW-1:0]   r_out_col;
    logic [HW-1:0]   r_out_row;
    logic [SW-1:0]   r_dy;
    logic [SW-1:0]   r_dx;
    logic            r_pend;
    logic            r_acc_last;
    logic [SUMW-1:0] r_sum [bbf_pkg::LANES];
    logic            r_out_valid;
    logic [31:0]     r_out_pixel;
    logic            r_out_end;

    logic [WW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [RW-1:0]   r_eff;
    logic [SW-1:0]   side;
    logic            cfg_wr;
    logic            cfg_hit;
    logic            accept;
    logic            do_write;
    logic            out_load;
    logic [HW-1:0]   need_row;
    logic [CW-1:0]   need_col;
    logic            out_ready;
    logic [YW-1:0]   ypos;
    logic [XW-1:0]   xpos;
    logic            in_frame;
    logic [31:0]     rdata;
    logic [$clog2(DEPTH)-1:0] waddr;
    logic [$clog2(DEPTH)-1:0] raddr;
    logic            win_last;
    logic            last_pix;
    logic [MW-1:0]   recip_tab [MAX_RADIUS+1];
    logic [MW-1:0]   recip;
    logic [PW-1:0]   prod [bbf_pkg::LANES];
    logic [31:0]     div_pixel;

    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_frame_width);
        end
        if (r_frame_height == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_frame_height) > 32'(bbf_pkg::MAX_HEIGHT)) begin
            h_eff = HW'(bbf_pkg::MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_frame_height);
        end
        if (32'(r_radius) > 32'(MAX_RADIUS)) begin
            r_eff = RW'(MAX_RADIUS);
        end else begin
            r_eff = RW'(r_radius);
        end
    end

    assign side = SW'({r_eff, 1'b1});

    // The window sum is divided by the area through a rounded-up reciprocal that is exact
    // for every sum the window can reach.
    for (genvar k = 0; k <= MAX_RADIUS; k++) begin : g_recip
        localparam int A = (2 * k + 1) * (2 * k + 1);
        assign recip_tab[k] = MW'(((1 << SH) + A - 1) / A);
    end

    assign recip = recip_tab[r_eff];

    always_comb begin
        for (int l = 0; l < bbf_pkg::LANES; l++) begin
            prod[l] = PW'(r_sum[l]) * PW'(recip);
            div_pixel[l*bbf_pkg::CH_W +: bbf_pkg::CH_W] = prod[l][SH +: bbf_pkg::CH_W];
        end
    end

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_hit = cfg_wr && (paddr[3:2] inside {bbf_pkg::REG_WIDTH, bbf_pkg::REG_HEIGHT,
                                                   bbf_pkg::REG_RADIUS});

    always_comb begin
        case (paddr[3:2])
            bbf_pkg::REG_WIDTH:  prdata = 32'(r_frame_width);
            bbf_pkg::REG_HEIGHT: prdata = 32'(r_frame_height);
            bbf_pkg::REG_RADIUS: prdata = 32'(r_radius);
            default:             prdata = '0;
        endcase
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign do_write = accept && !i_action && (r_in_row < h_eff);
    assign waddr    = {r_in_row[RB-1:0], r_in_col};
    assign out_load = (r_state == ST_DIV) && (!r_out_valid || i_ready) && !cfg_hit;

    always_comb begin
        if (32'(r_out_row) + 32'(r_eff) > 32'(h_eff) - 32'd1) begin
            need_row = h_eff - HW'(1);
        end else begin
            need_row = r_out_row + HW'(r_eff);
        end
        if (32'(r_out_col) + 32'(r_eff) > 32'(w_eff) - 32'd1) begin
            need_col = CW'(w_eff - WW'(1));
        end else begin
            need_col = r_out_col + CW'(r_eff);
        end
        out_ready = (need_row < r_in_row) ||
                    ((need_row == r_in_row) && (need_col < r_in_col));
    end

    assign ypos = YW'(r_out_row) + YW'(r_dy) - YW'(r_eff);
    assign xpos = XW'(r_out_col) + XW'(r_dx) - XW'(r_eff);
    assign in_frame = (YW'(r_out_row) + YW'(r_dy) >= YW'(r_eff)) && (ypos < YW'(h_eff)) &&
                      (XW'(r_out_col) + XW'(r_dx) >= XW'(r_eff)) && (xpos < XW'(w_eff));
    assign raddr    = {ypos[RB-1:0], xpos[CW-1:0]};
    assign win_last = (r_dy == side - SW'(1)) && (r_dx == side - SW'(1));
    assign last_pix = (r_out_row == h_eff - HW'(1)) &&
                      (WW'(r_out_col) == w_eff - WW'(1));

    bbf_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (do_write),
        .i_waddr(waddr),
        .i_wdata(i_pixel_in),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bbf_pkg::CFG_W'(640);
            r_frame_height <= bbf_pkg::CFG_W'(480);
            r_radius       <= bbf_pkg::RAD_W'(2);
            r_state        <= ST_IDLE;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_pend         <= 1'b0;
            r_acc_last     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_hit) begin
                case (paddr[3:2])
                    bbf_pkg::REG_WIDTH:  r_frame_width  <= pwdata[bbf_pkg::CFG_W-1:0];
                    bbf_pkg::REG_HEIGHT: r_frame_height <= pwdata[bbf_pkg::CFG_W-1:0];
                    bbf_pkg::REG_RADIUS: r_radius       <= pwdata[bbf_pkg::RAD_W-1:0];
                    default: ;
                endcase
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                case (r_state)
                    ST_IDLE: begin
                        if (accept) begin
                            if (do_write) begin
                                if (WW'(r_in_col) + WW'(1) >= w_eff) begin
                                    r_in_col <= '0;
                                    r_in_row <= r_in_row + HW'(1);
                                end else begin
                                    r_in_col <= r_in_col + CW'(1);
                                end
                            end
                            r_state <= ST_CHECK;
                        end
                    end
                    ST_CHECK: begin
                        if (r_out_row >= h_eff) begin
                            r_in_col  <= '0;
                            r_in_row  <= '0;
                            r_out_col <= '0;
                            r_out_row <= '0;
                            r_state   <= ST_IDLE;
                        end else if (out_ready) begin
                            r_dy       <= '0;
                            r_dx       <= '0;
                            r_pend     <= 1'b0;
                            r_acc_last <= 1'b0;
                            for (int l = 0; l < bbf_pkg::LANES; l++) begin
                                r_sum[l] <= '0;
                            end
                            r_state <= ST_READ;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_READ: begin
                        if (r_pend) begin
                            for (int l = 0; l < bbf_pkg::LANES; l++) begin
                                r_sum[l] <= r_sum[l] +
                                            SUMW'(rdata[l*bbf_pkg::CH_W +: bbf_pkg::CH_W]);
                            end
                        end
                        if (r_acc_last) begin
                            r_pend  <= 1'b0;
                            r_state <= ST_DIV;
                        end else begin
                            r_pend <= in_frame;
                            if (win_last) begin
                                r_acc_last <= 1'b1;
                            end else if (r_dx == side - SW'(1)) begin
                                r_dx <= '0;
                                r_dy <= r_dy + SW'(1);
                            end else begin
                                r_dx <= r_dx + SW'(1);
                            end
                        end
                    end
                    ST_DIV: begin
                        if (out_load) begin
                            r_out_pixel <= div_pixel;
                            r_out_end   <= last_pix;
                            r_state     <= ST_IDLE;
                            if (last_pix) begin
                                r_in_col  <= '0;
                                r_in_row  <= '0;
                                r_out_col <= '0;
                                r_out_row <= '0;
                            end else if (WW'(r_out_col) + WW'(1) >= w_eff) begin
                                r_out_col <= '0;
                                r_out_row <= r_out_row + HW'(1);
                            end else begin
                                r_out_col <= r_out_col + CW'(1);
                            end
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_out_pixel;
    assign o_frame_end = r_out_end;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == ST_IDLE))
        else $error("ready raised while busy");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_out))
        else $error("result beat dropped");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (r_out_row < h_eff))
        else $error("window fetch outside frame rows");

endmodule
